// ----- hw/rtl/chtp_pkg.sv -----
// ----------------------------------------------------------------------------
// chtp_pkg
// Shared types and constants for the consistent-hash transport picker.
// ----------------------------------------------------------------------------
package chtp_pkg;

    localparam int KEY_W     = 31;
    localparam int CONN_W    = 4;
    localparam int SLOT_W    = 6;
    localparam int OWNERS_W  = 4;
    localparam int ENTRIES_W = 7;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int OWNERS_MAX = 8;

    typedef enum logic [1:0] {
        ACT_LOOKUP  = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_AWARE       = 3'd0,
        CFG_RING_SPACE       = 3'd1,
        CFG_OWNERS_PER_KEY   = 3'd2,
        CFG_RING_ENTRIES     = 3'd3,
        CFG_CONNECTION_COUNT = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_KEY,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_SEARCH_END,
        ST_MOD_PICK,
        ST_ROTATE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_RR_REDUCE,
        ST_RR_SCAN,
        ST_FINISH
    } state_t;

    // Request and reply of the shared remainder unit.
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [KEY_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] rem;
    } rem_rsp_t;

endpackage

// ----- hw/rtl/chtp_rem.sv -----
// ----------------------------------------------------------------------------
// chtp_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module chtp_rem (
    input  logic              clk,
    input  logic              rst_n,
    input  chtp_pkg::rem_req_t req,
    output chtp_pkg::rem_rsp_t rsp
);

    localparam int W = chtp_pkg::KEY_W;

    logic [W-1:0]         dvd_reg, dvd_next;
    logic [W-1:0]         div_reg, div_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [$clog2(W)-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[W-1]};
        if (req.start)
        begin
            dvd_next = req.dividend;
            div_next = req.divisor;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(W))'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- hw/rtl/consistent_hash_transport_picker_unit.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_transport_picker_unit
// Picks a connection for a request from a hash ring or a round-robin pool.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   action, request_hash, random_pick,
//                                            entry_slot, entry_point,
//                                            entry_connection
// out       output     out_valid / out_stall found, connection_id, claimed
// cfg       input      cfg_write             cfg_index, cfg_data
//
// Items are handled one at a time: a load, release or unused action goes straight
// to the finish state, a round-robin lookup through pointer reduction and a pool
// scan, and a ring lookup through up to two remainder passes, a binary search, the
// rotation steps and the owner probes. Reset clears busy flags, rotation pointer,
// configuration registers and handshake; the ring memory is not reset. The next
// transfer is taken while a stalled result waits in the output.
//
module consistent_hash_transport_picker_unit #(
    parameter int RING_DEPTH  = 64,
    parameter int CONNECTIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [chtp_pkg::KEY_W-1:0]         request_hash,
    input  logic [chtp_pkg::KEY_W-1:0]         random_pick,
    input  logic [chtp_pkg::SLOT_W-1:0]        entry_slot,
    input  logic [chtp_pkg::KEY_W-1:0]         entry_point,
    input  logic [chtp_pkg::CONN_W-1:0]        entry_connection,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [chtp_pkg::CONN_W-1:0]        connection_id,
    output logic                               claimed,
    input  logic                               cfg_write,
    input  logic [chtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chtp_pkg::KEY_W-1:0]         cfg_data
);

    localparam int KW = chtp_pkg::KEY_W;
    localparam int CNW = chtp_pkg::CONN_W;
    localparam int OW = chtp_pkg::OWNERS_W;
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NW = $clog2(RING_DEPTH + 1);
    localparam int CW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int PW = $clog2(CONNECTIONS + 1);
    localparam int MW = KW + CNW;

    // Configuration registers.
    logic                          hash_aware_reg;
    logic [KW-1:0]                 ring_space_reg;
    logic [chtp_pkg::OWNERS_W-1:0] owners_reg;
    logic [chtp_pkg::ENTRIES_W-1:0] entries_reg;
    logic [chtp_pkg::COUNT_W-1:0]  count_reg;

    // Ring memory: point in the upper bits, owner in the lower bits.
    logic [MW-1:0] ring_mem [RING_DEPTH];
    logic [MW-1:0] rd_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;

    chtp_pkg::state_t state_reg, state_next;
    logic [CONNECTIONS-1:0] busy_reg, busy_next;
    logic [CW-1:0] ptr_reg, ptr_next;

    // Per-transfer working registers.
    logic [KW-1:0]  key_reg, key_next;
    logic [KW-1:0]  pick_reg, pick_next;
    logic [KW-1:0]  h_reg, h_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  lo_reg, lo_next;
    logic [NW-1:0]  hi1_reg, hi1_next;
    logic [AW-1:0]  mid_reg, mid_next;
    logic           best_ok_reg, best_ok_next;
    logic [KW-1:0]  best_p_reg, best_p_next;
    logic [AW-1:0]  best_i_reg, best_i_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [3:0]     owners_eff_reg, owners_eff_next;
    logic [2:0]     off_reg, off_next;
    logic [2:0]     rot_reg, rot_next;
    logic [3:0]     probe_reg, probe_next;
    logic [PW-1:0]  cnt_reg, cnt_next;
    logic [PW-1:0]  scan_reg, scan_next;
    logic           res_found_reg, res_found_next;
    logic [CNW-1:0] res_id_reg, res_id_next;
    logic           res_claimed_reg, res_claimed_next;

    // Output register.
    logic           out_valid_reg, out_valid_next;
    logic           found_reg, claimed_reg;
    logic [CNW-1:0] id_reg;
    logic           out_load;

    chtp_pkg::rem_req_t rem_req;
    chtp_pkg::rem_rsp_t rem_rsp;

    chtp_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // Clamped sizes and helper values.
    logic [31:0]   n32, c32, own32, owner32, rel32, slot32, cand32;
    logic [NW-1:0] n_eff;
    logic [PW-1:0] c_eff;
    logic [3:0]    owners_eff;
    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid_full;
    logic [KW-1:0] rd_point;
    logic [CNW-1:0] rd_owner;
    logic [AW-1:0] idx_inc;
    logic          owner_free;
    logic          accept;

    always_comb
    begin
        n32   = (32'(entries_reg) > 32'(RING_DEPTH)) ? 32'(RING_DEPTH) : 32'(entries_reg);
        n_eff = n32[NW-1:0];
        c32   = (32'(count_reg) > 32'(CONNECTIONS)) ? 32'(CONNECTIONS) : 32'(count_reg);
        c_eff = c32[PW-1:0];
        own32 = (32'(owners_reg) > 32'(chtp_pkg::OWNERS_MAX)) ?
                32'(chtp_pkg::OWNERS_MAX) : 32'(owners_reg);
        owners_eff = own32[3:0];
        mid_sum  = (NW+1)'(lo_reg) + (NW+1)'(hi1_reg) - 1'b1;
        mid_full = mid_sum[NW:1];
        rd_point = rd_reg[MW-1:CNW];
        rd_owner = rd_reg[CNW-1:0];
        owner32  = 32'(rd_owner);
        owner_free = (owner32 < 32'(CONNECTIONS)) && !busy_reg[owner32[CW-1:0]];
        rel32  = 32'(entry_connection);
        slot32 = 32'(entry_slot);
        cand32 = 32'(ptr_reg);
        idx_inc = ((NW'(idx_reg) + 1'b1) == n_reg) ? '0 : AW'(idx_reg + 1'b1);
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != chtp_pkg::ST_IDLE);
    assign out_load = !out_valid_reg || !out_stall;

    // Next state and datapath control.
    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        ptr_next         = ptr_reg;
        key_next         = key_reg;
        pick_next        = pick_reg;
        h_next           = h_reg;
        n_next           = n_reg;
        lo_next          = lo_reg;
        hi1_next         = hi1_reg;
        mid_next         = mid_reg;
        best_ok_next     = best_ok_reg;
        best_p_next      = best_p_reg;
        best_i_next      = best_i_reg;
        base_next        = base_reg;
        idx_next         = idx_reg;
        owners_eff_next  = owners_eff_reg;
        off_next         = off_reg;
        rot_next         = rot_reg;
        probe_next       = probe_reg;
        cnt_next         = cnt_reg;
        scan_next        = scan_reg;
        res_found_next   = res_found_reg;
        res_id_next      = res_id_reg;
        res_claimed_next = res_claimed_reg;
        out_valid_next   = out_valid_reg && out_stall;
        mem_we           = 1'b0;
        mem_waddr        = slot32[AW-1:0];
        mem_re           = 1'b0;
        mem_raddr        = idx_reg;
        rem_req.start    = 1'b0;
        rem_req.dividend = key_reg;
        rem_req.divisor  = ring_space_reg;

        case (state_reg)
            chtp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next         = request_hash;
                    pick_next        = random_pick;
                    res_found_next   = 1'b0;
                    res_id_next      = '0;
                    res_claimed_next = 1'b0;
                    n_next           = n_eff;
                    cnt_next         = c_eff;
                    owners_eff_next  = owners_eff;
                    lo_next          = '0;
                    hi1_next         = n_eff;
                    best_ok_next     = 1'b0;
                    state_next       = chtp_pkg::ST_FINISH;
                    case (chtp_pkg::action_t'(action))
                        chtp_pkg::ACT_LOAD:
                        begin
                            mem_we = (slot32 < 32'(RING_DEPTH));
                        end
                        chtp_pkg::ACT_RELEASE:
                        begin
                            if (rel32 < 32'(CONNECTIONS))
                                busy_next[rel32[CW-1:0]] = 1'b0;
                        end
                        chtp_pkg::ACT_LOOKUP:
                        begin
                            if (hash_aware_reg && (n_eff != '0))
                            begin
                                if (ring_space_reg != '0)
                                begin
                                    rem_req.start    = 1'b1;
                                    rem_req.dividend = request_hash;
                                    state_next       = chtp_pkg::ST_MOD_KEY;
                                end
                                else
                                begin
                                    h_next     = request_hash;
                                    state_next = chtp_pkg::ST_SEARCH_RD;
                                end
                            end
                            else if (c_eff != '0)
                                state_next = chtp_pkg::ST_RR_REDUCE;
                        end
                        default:
                        begin
                            state_next = chtp_pkg::ST_FINISH;
                        end
                    endcase
                end
            end
            chtp_pkg::ST_MOD_KEY:
            begin
                if (rem_rsp.done)
                begin
                    h_next     = rem_rsp.rem;
                    state_next = chtp_pkg::ST_SEARCH_RD;
                end
            end
            chtp_pkg::ST_SEARCH_RD:
            begin
                if (lo_reg < hi1_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mid_full[AW-1:0];
                    mid_next   = mid_full[AW-1:0];
                    state_next = chtp_pkg::ST_SEARCH_CMP;
                end
                else
                begin
                    base_next  = best_ok_reg ? best_i_reg : '0;
                    state_next = chtp_pkg::ST_SEARCH_END;
                end
            end
            chtp_pkg::ST_SEARCH_CMP:
            begin
                if ((rd_point >= h_reg) && (!best_ok_reg || (rd_point < best_p_reg)))
                begin
                    best_ok_next = 1'b1;
                    best_p_next  = rd_point;
                    best_i_next  = mid_reg;
                end
                if (rd_point < h_reg)
                begin
                    lo_next    = NW'(mid_reg) + 1'b1;
                    state_next = chtp_pkg::ST_SEARCH_RD;
                end
                else if (rd_point > h_reg)
                begin
                    hi1_next   = NW'(mid_reg);
                    state_next = chtp_pkg::ST_SEARCH_RD;
                end
                else
                begin
                    base_next  = mid_reg;
                    state_next = chtp_pkg::ST_SEARCH_END;
                end
            end
            chtp_pkg::ST_SEARCH_END:
            begin
                if (owners_eff_reg == '0)
                    state_next = chtp_pkg::ST_FINISH;
                else
                begin
                    rem_req.start    = 1'b1;
                    rem_req.dividend = pick_reg;
                    rem_req.divisor  = KW'(owners_eff_reg);
                    state_next       = chtp_pkg::ST_MOD_PICK;
                end
            end
            chtp_pkg::ST_MOD_PICK:
            begin
                if (rem_rsp.done)
                begin
                    off_next   = rem_rsp.rem[2:0];
                    rot_next   = rem_rsp.rem[2:0];
                    idx_next   = base_reg;
                    probe_next = '0;
                    state_next = chtp_pkg::ST_ROTATE;
                end
            end
            chtp_pkg::ST_ROTATE:
            begin
                // Step the start index forward by the owner offset, wrapping on the ring.
                if (rot_reg == '0)
                    state_next = chtp_pkg::ST_PROBE_RD;
                else
                begin
                    idx_next = idx_inc;
                    rot_next = rot_reg - 1'b1;
                end
            end
            chtp_pkg::ST_PROBE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = chtp_pkg::ST_PROBE_CHK;
            end
            chtp_pkg::ST_PROBE_CHK:
            begin
                res_found_next = 1'b1;
                res_id_next    = rd_owner;
                if (owner_free)
                begin
                    busy_next[owner32[CW-1:0]] = 1'b1;
                    res_claimed_next = 1'b1;
                    state_next       = chtp_pkg::ST_FINISH;
                end
                else if ((probe_reg + 1'b1) == owners_eff_reg)
                    state_next = chtp_pkg::ST_FINISH;
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    if ((4'(off_reg) + 1'b1) == owners_eff_reg)
                    begin
                        off_next = '0;
                        idx_next = base_reg;
                    end
                    else
                    begin
                        off_next = off_reg + 1'b1;
                        idx_next = idx_inc;
                    end
                    state_next = chtp_pkg::ST_PROBE_RD;
                end
            end
            chtp_pkg::ST_RR_REDUCE:
            begin
                if (PW'(ptr_reg) >= cnt_reg)
                    ptr_next = CW'(PW'(ptr_reg) - cnt_reg);
                else
                begin
                    scan_next  = '0;
                    state_next = chtp_pkg::ST_RR_SCAN;
                end
            end
            chtp_pkg::ST_RR_SCAN:
            begin
                ptr_next = ((PW'(ptr_reg) + 1'b1) == cnt_reg) ? '0 : CW'(ptr_reg + 1'b1);
                if (!busy_reg[ptr_reg])
                begin
                    busy_next[ptr_reg] = 1'b1;
                    res_found_next     = 1'b1;
                    res_claimed_next   = 1'b1;
                    res_id_next        = cand32[CNW-1:0];
                    state_next         = chtp_pkg::ST_FINISH;
                end
                else if ((scan_reg + 1'b1) == cnt_reg)
                    state_next = chtp_pkg::ST_FINISH;
                else
                    scan_next = scan_reg + 1'b1;
            end
            chtp_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = chtp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chtp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chtp_pkg::ST_IDLE;
            busy_reg       <= '0;
            ptr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            hash_aware_reg <= 1'b0;
            ring_space_reg <= '1;
            owners_reg     <= OW'(1);
            entries_reg    <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (chtp_pkg::cfg_index_t'(cfg_index))
                    chtp_pkg::CFG_HASH_AWARE:       hash_aware_reg <= cfg_data[0];
                    chtp_pkg::CFG_RING_SPACE:       ring_space_reg <= cfg_data;
                    chtp_pkg::CFG_OWNERS_PER_KEY:
                        owners_reg <= cfg_data[chtp_pkg::OWNERS_W-1:0];
                    chtp_pkg::CFG_RING_ENTRIES:
                        entries_reg <= cfg_data[chtp_pkg::ENTRIES_W-1:0];
                    chtp_pkg::CFG_CONNECTION_COUNT:
                        count_reg <= cfg_data[chtp_pkg::COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        pick_reg        <= pick_next;
        h_reg           <= h_next;
        n_reg           <= n_next;
        lo_reg          <= lo_next;
        hi1_reg         <= hi1_next;
        mid_reg         <= mid_next;
        best_ok_reg     <= best_ok_next;
        best_p_reg      <= best_p_next;
        best_i_reg      <= best_i_next;
        base_reg        <= base_next;
        idx_reg         <= idx_next;
        owners_eff_reg  <= owners_eff_next;
        off_reg         <= off_next;
        rot_reg         <= rot_next;
        probe_reg       <= probe_next;
        cnt_reg         <= cnt_next;
        scan_reg        <= scan_next;
        res_found_reg   <= res_found_next;
        res_id_reg      <= res_id_next;
        res_claimed_reg <= res_claimed_next;
        if ((state_reg == chtp_pkg::ST_FINISH) && out_load)
        begin
            found_reg   <= res_found_reg;
            id_reg      <= res_id_reg;
            claimed_reg <= res_claimed_reg;
        end
    end

    // Ring memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= {entry_point, entry_connection};
        if (mem_re)
            rd_reg <= ring_mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign connection_id = id_reg;
    assign claimed       = claimed_reg;

`ifndef SYNTH
    // A claim is only reported for a returned connection.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!claimed || found))
        else $error("claimed without found");

    // With no connection found, the id reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (connection_id == '0))
        else $error("nonzero id without found");

    // Once a transfer is taken, input is held off for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");
`endif

endmodule
